// File: rtl/scc_pkg.sv
// Shared types and constants for the substring containment check.
package scc_pkg;

  localparam int MAX_LEN_DEF = 64;
  localparam int QDEPTH      = 4;
  localparam int QPTR_W      = $clog2(QDEPTH);

  typedef enum logic {
    OP_FIRST  = 1'b0,
    OP_SECOND = 1'b1
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] ch;
    logic       last;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SETUP,
    ST_READ,
    ST_CMP,
    ST_DONE
  } st_t;

endpackage

// File: rtl/substring_containment_check.sv
// Substring containment check: top level joining front end, queue and back end.
// Path: a plain character passes the front hold register and a queue entry before it is
//   written to its word buffer; a pair end passes ST_SETUP, then N character compares, where
//   N is at most (Lbig-Lsmall+1)*Lsmall, each through ST_READ and ST_CMP because each word
//   buffer has a single registered read port, and the result is registered from ST_DONE.
// Throughput: one character per cycle while loading; the search stalls intake.
// Reset: synchronous, active high; clears lengths, flags, queue and result valid.
module substring_containment_check import scc_pkg::*; #(
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] ch
  input  logic       s_tuser,   // [0] kind: 0 first word, 1 second word
  input  logic       s_tlast,   // pair_end
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata    // [0] contains, [1] overflow, [7:2] zero
);

  logic push;
  logic push_ready;
  cmd_t push_data;
  logic q_valid;
  logic q_pop;
  cmd_t q_data;

  // Register and classify each incoming transfer.
  scc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .s_tlast    (s_tlast),
    .push       (push),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // Hold commands while the back end is busy searching.
  scc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_ready (push_ready),
    .push_data  (push_data),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .q_data     (q_data)
  );

  // Store characters, walk every alignment on pair end, present the result.
  scc_back #(
    .MAX_LEN (MAX_LEN)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

// File: rtl/scc_front.sv
// Input stage: register one transfer and classify it into a command.
module scc_front import scc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,
  input  logic       s_tuser,
  input  logic       s_tlast,
  output logic       push,
  input  logic       push_ready,
  output cmd_t       push_data
);

  logic hold_valid;
  cmd_t hold;

  assign s_tready  = !hold_valid || push_ready;
  assign push      = hold_valid && push_ready;
  assign push_data = hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (s_tready) begin
      hold_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      hold.op   <= s_tuser ? OP_SECOND : OP_FIRST;
      hold.ch   <= s_tdata;
      hold.last <= s_tlast;
    end
  end

endmodule

// File: rtl/scc_queue.sv
// Short command queue between the front and back ends.
module scc_queue import scc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic push_ready,
  input  cmd_t push_data,
  output logic q_valid,
  input  logic q_pop,
  output cmd_t q_data
);

  cmd_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign push_ready = count != (QPTR_W+1)'(QDEPTH);
  assign q_valid    = count != '0;
  assign q_data     = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, q_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: rtl/scc_back.sv
// Back end: word buffers, alignment search and result register.
module scc_back import scc_pkg::*; #(
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_valid,
  input  cmd_t       q_data,
  output logic       q_pop,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata
);

  localparam int LEN_W = $clog2(MAX_LEN + 1);
  localparam int IDX_W = $clog2(MAX_LEN);

  st_t st, st_next;

  logic [7:0]       first_mem  [MAX_LEN];
  logic [7:0]       second_mem [MAX_LEN];
  logic [7:0]       first_rd;
  logic [7:0]       second_rd;
  logic [LEN_W-1:0] first_len;
  logic [LEN_W-1:0] second_len;
  logic             exceeded;
  logic             swap;
  logic             swap_c;
  logic [LEN_W-1:0] big_len;
  logic [LEN_W-1:0] small_len;
  logic [LEN_W-1:0] small_c;
  logic [LEN_W-1:0] pos;
  logic [LEN_W-1:0] k;
  logic [LEN_W-1:0] big_idx;
  logic [IDX_W-1:0] first_addr;
  logic [IDX_W-1:0] second_addr;
  logic             hit;
  logic             match;
  logic             k_last;
  logic             pos_last;
  logic             wr_first;
  logic             wr_second;
  logic             full_first;
  logic             full_second;
  logic             done_go;
  logic             out_valid;
  logic             out_contains;
  logic             out_overflow;

  assign swap_c   = second_len > first_len;
  assign small_c  = swap_c ? first_len : second_len;
  assign big_idx  = pos + k;
  assign match    = first_rd == second_rd;
  assign k_last   = LEN_W'(k + 1'b1) == small_len;
  assign pos_last = ((LEN_W+1)'(pos) + (LEN_W+1)'(small_len) + 1'b1) > (LEN_W+1)'(big_len);

  assign first_addr  = swap ? k[IDX_W-1:0] : big_idx[IDX_W-1:0];
  assign second_addr = swap ? big_idx[IDX_W-1:0] : k[IDX_W-1:0];

  assign full_first  = first_len == LEN_W'(MAX_LEN);
  assign full_second = second_len == LEN_W'(MAX_LEN);

  assign m_tvalid = out_valid;
  assign m_tdata  = {6'b0, out_overflow, out_contains};

  // next state
  always_comb begin
    st_next = st;
    case (st)
      ST_LOAD: begin
        if (q_valid && q_data.last) st_next = ST_SETUP;
      end
      ST_SETUP: begin
        st_next = (small_c == '0) ? ST_DONE : ST_READ;
      end
      ST_READ: st_next = ST_CMP;
      ST_CMP: begin
        if (match && k_last) st_next = ST_DONE;
        else if (!match && pos_last) st_next = ST_DONE;
        else st_next = ST_READ;
      end
      ST_DONE: begin
        if (done_go) st_next = ST_LOAD;
      end
      default: st_next = ST_LOAD;
    endcase
  end

  // outputs
  always_comb begin
    q_pop     = (st == ST_LOAD) && q_valid;
    wr_first  = q_pop && (q_data.op == OP_FIRST) && !full_first;
    wr_second = q_pop && (q_data.op == OP_SECOND) && !full_second;
    done_go   = (st == ST_DONE) && (!out_valid || m_tready);
  end

  always_ff @(posedge clk) begin
    if (wr_first) begin
      first_mem[first_len[IDX_W-1:0]] <= q_data.ch;
    end
    first_rd <= first_mem[first_addr];
  end

  always_ff @(posedge clk) begin
    if (wr_second) begin
      second_mem[second_len[IDX_W-1:0]] <= q_data.ch;
    end
    second_rd <= second_mem[second_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st         <= ST_LOAD;
      first_len  <= '0;
      second_len <= '0;
      exceeded   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      st <= st_next;
      if (wr_first) first_len <= first_len + 1'b1;
      if (wr_second) second_len <= second_len + 1'b1;
      if (q_pop && !wr_first && !wr_second) exceeded <= 1'b1;
      if (done_go) begin
        first_len  <= '0;
        second_len <= '0;
        exceeded   <= 1'b0;
        out_valid  <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // search datapath
  always_ff @(posedge clk) begin
    case (st)
      ST_SETUP: begin
        swap      <= swap_c;
        big_len   <= swap_c ? second_len : first_len;
        small_len <= small_c;
        pos       <= '0;
        k         <= '0;
        hit       <= small_c == '0;
      end
      ST_CMP: begin
        if (match) begin
          k   <= k + 1'b1;
          hit <= k_last;
        end else begin
          pos <= pos + 1'b1;
          k   <= '0;
          hit <= 1'b0;
        end
      end
      default: ;
    endcase
    if (done_go) begin
      out_contains <= hit;
      out_overflow <= exceeded;
    end
  end

endmodule

// File: rtl/scc_checker.sv
// Port-level checks for the substring containment check, bound to the top level.
module scc_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata
);

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("result changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_reset_ready: assert property (@(posedge clk)
    rst |=> s_tready)
    else $error("input not ready right after reset");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[7:2] == 6'b0)
    else $error("padding bits of result not zero");

endmodule

bind substring_containment_check scc_checker u_scc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// File: tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for the substring containment check: pair streams in, verdicts out.
module testbench;
  import scc_pkg::*;

  localparam int CLK_PERIOD   = 8;
  localparam int RANDOM_ITEMS = 500;
  // Leave ample room above the slowest legal run.
  localparam int CYCLE_LIMIT  = 400000;
  // Quiet cycles after the last verdict so a stray result still gets seen.
  localparam int DRAIN_CYCLES = 100;
  localparam int LONG_HOLD    = 1500;

  typedef logic [7:0] word_q[$];

  // Verdict bits as they leave on m_tdata, highest bit first.
  typedef struct packed {
    logic overflow;
    logic contains;
  } verdict_t;

  // Tracks both word buffers and computes the verdict due for each pair.
  class containment_scoreboard;
    logic [7:0] first_word [MAX_LEN_DEF];
    logic [7:0] second_word [MAX_LEN_DEF];
    int         first_len;
    int         second_len;
    bit         too_long;
    verdict_t   verdicts_due[$];
    int         mismatches;

    function new();
      first_len  = 0;
      second_len = 0;
      too_long   = 0;
      mismatches = 0;
    endfunction

    function int pending();
      return verdicts_due.size();
    endfunction

    // Fold one accepted character into the words; on pair end, queue a verdict.
    function void note_transfer(cmd_t item);
      logic [7:0] longer [MAX_LEN_DEF];
      logic [7:0] shorter [MAX_LEN_DEF];
      int         long_len;
      int         short_len;
      bit         hit;
      bit         aligned;
      verdict_t   v;
      if (item.op == OP_FIRST) begin
        if (first_len < MAX_LEN_DEF) begin
          first_word[first_len] = item.ch;
          first_len++;
        end else begin
          too_long = 1'b1;
        end
      end else begin
        if (second_len < MAX_LEN_DEF) begin
          second_word[second_len] = item.ch;
          second_len++;
        end else begin
          too_long = 1'b1;
        end
      end
      if (!item.last) return;
      // On a tie the second word plays the shorter one.
      if (second_len > first_len) begin
        longer    = second_word;
        long_len  = second_len;
        shorter   = first_word;
        short_len = first_len;
      end else begin
        longer    = first_word;
        long_len  = first_len;
        shorter   = second_word;
        short_len = second_len;
      end
      hit = 1'b0;
      for (int pos = 0; pos + short_len <= long_len && !hit; pos++) begin
        aligned = 1'b1;
        for (int k = 0; k < short_len; k++) begin
          if (longer[pos + k] != shorter[k]) aligned = 1'b0;
        end
        if (aligned) hit = 1'b1;
      end
      v.contains = hit;
      v.overflow = too_long;
      verdicts_due.push_back(v);
      first_len  = 0;
      second_len = 0;
      too_long   = 1'b0;
    endfunction

    // Compare one accepted verdict against the oldest one due.
    function void check_result(logic [7:0] data);
      verdict_t v;
      if (verdicts_due.size() == 0) begin
        $error("verdict with no pair pending: tdata=%h", data);
        mismatches++;
        return;
      end
      v = verdicts_due.pop_front();
      if (data[0] !== v.contains) begin
        $error("contains: expected %0b, actual %0b", v.contains, data[0]);
        mismatches++;
      end
      if (data[1] !== v.overflow) begin
        $error("overflow: expected %0b, actual %0b", v.overflow, data[1]);
        mismatches++;
      end
    endfunction
  endclass

  logic       clk;
  logic       rst;
  logic       s_tvalid;
  logic       s_tready;
  logic [7:0] s_tdata;   // [7:0] ch
  logic       s_tuser;   // [0] kind
  logic       s_tlast;   // pair_end
  logic       m_tvalid;
  logic       m_tready;
  logic [7:0] m_tdata;   // [0] contains, [1] overflow, [7:2] zero

  containment_scoreboard sb = new();

  int items_sent;
  int cycle_count;
  int hold_request;   // long receiver hold-off, picked up by the receiver
  int tx_stretch;
  bit tx_calm;

  substring_containment_check DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Offer one character; hold it until the transfer, then note it for prediction.
  // The sender alternates between calm stretches (back to back) and idling ones.
  task automatic send_item(input cmd_t item);
    int gap;
    if (tx_stretch == 0) begin
      tx_stretch = $urandom_range(5, 40);
      tx_calm    = ($urandom_range(0, 3) == 0);
    end
    tx_stretch--;
    gap = tx_calm ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser  = item.op;
    s_tdata  = item.ch;
    s_tlast  = item.last;
    do @(posedge clk); while (!s_tready);
    sb.note_transfer(item);
    items_sent++;
    @(negedge clk);
  endtask

  // Stream both words of a pair, either word by word or interleaved with each
  // word keeping its own order; the final transfer carries pair_end.
  task automatic send_pair(input word_q first_w, input word_q second_w, input bit interleave);
    cmd_t seq[$];
    cmd_t item;
    int   i;
    int   j;
    bit   take_first;
    i = 0;
    j = 0;
    while (i < first_w.size() || j < second_w.size()) begin
      take_first = (j >= second_w.size()) ||
                   (i < first_w.size() && (!interleave || $urandom_range(0, 1) == 0));
      item.last = 1'b0;
      if (take_first) begin
        item.op = OP_FIRST;
        item.ch = first_w[i];
        i++;
      end else begin
        item.op = OP_SECOND;
        item.ch = second_w[j];
        j++;
      end
      seq.push_back(item);
    end
    seq[seq.size() - 1].last = 1'b1;
    foreach (seq[n]) send_item(seq[n]);
  endtask

  // Narrow words draw from two letters so partial matches are common.
  function automatic word_q random_word(int n, bit narrow);
    word_q w;
    for (int k = 0; k < n; k++) begin
      if (narrow) w.push_back($urandom_range(0, 1) ? 8'h61 : 8'h62);
      else        w.push_back(8'($urandom_range(0, 255)));
    end
    return w;
  endfunction

  // Build a random pair; half the time the shorter word is cut out of the
  // longer one, sometimes with one character spoiled. Wide pairs can run past
  // the buffer size so overflow gets exercised.
  task automatic random_pair(input bit wide);
    word_q longw;
    word_q shortw;
    int    la;
    int    ls;
    int    off;
    bit    narrow;
    bit    swap;
    narrow = ($urandom_range(0, 1) == 1);
    la     = wide ? $urandom_range(MAX_LEN_DEF - 4, MAX_LEN_DEF + 6) : $urandom_range(0, 8);
    longw  = random_word(la, narrow);
    if ($urandom_range(0, 1) == 1) begin
      ls  = $urandom_range(0, la);
      off = $urandom_range(0, la - ls);
      for (int k = 0; k < ls; k++) shortw.push_back(longw[off + k]);
      if (ls > 0 && $urandom_range(0, 3) == 0)
        shortw[$urandom_range(0, ls - 1)] = 8'($urandom_range(0, 255));
    end else begin
      shortw = random_word($urandom_range(0, 8), narrow);
    end
    // The pair-end character always lands somewhere, so keep at least one.
    if (longw.size() + shortw.size() == 0) longw.push_back(8'($urandom_range(0, 255)));
    swap = ($urandom_range(0, 1) == 1);
    if (swap) send_pair(shortw, longw, $urandom_range(0, 4) == 0);
    else      send_pair(longw, shortw, $urandom_range(0, 4) == 0);
  endtask

  // Receiver: accept verdicts at the rising edge, drive tready at the falling
  // edge. Between verdicts draw a stall, with calm stretches mixed in; a long
  // hold-off request from the sender side overrides the draw.
  initial begin
    int  rx_wait;
    int  rx_stretch;
    bit  rx_calm;
    bit  need_draw;
    m_tready   = 1'b0;
    rx_wait    = 0;
    rx_stretch = 0;
    rx_calm    = 1'b0;
    need_draw  = 1'b1;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        sb.check_result(m_tdata);
        need_draw = 1'b1;
      end
      @(negedge clk);
      if (hold_request > 0) begin
        rx_wait      = hold_request;
        hold_request = 0;
        need_draw    = 1'b0;
      end else if (need_draw) begin
        if (rx_stretch == 0) begin
          rx_stretch = $urandom_range(3, 20);
          rx_calm    = ($urandom_range(0, 3) == 0);
        end
        rx_stretch--;
        rx_wait   = rx_calm ? 0 : $urandom_range(0, 10);
        need_draw = 1'b0;
      end
      m_tready = (rx_wait == 0);
      if (rx_wait > 0) rx_wait--;
    end
  end

  // Watchdog: a hung handshake or a missing verdict ends here.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    word_q a;
    word_q b;
    int    pairs;
    int    wide_done;
    bit    held;
    bit    paused;
    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = 8'h00;
    s_tuser      = OP_FIRST;
    s_tlast      = 1'b0;
    items_sent   = 0;
    hold_request = 0;
    tx_stretch   = 0;
    tx_calm      = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: equal words.
    a = '{8'h61, 8'h62};
    b = '{8'h61, 8'h62};
    send_pair(a, b, 1'b0);
    // Empty first word inside a one-character second word.
    a = {};
    b = '{8'hFF};
    send_pair(a, b, 1'b0);
    // Pair end on the first word, second word empty.
    a = '{8'h00};
    b = {};
    send_pair(a, b, 1'b0);
    // Second word shorter and inside the first.
    a = '{8'h61, 8'h62, 8'h63};
    b = '{8'h62};
    send_pair(a, b, 1'b0);
    // First word shorter and inside the second.
    a = '{8'h61, 8'h62};
    b = '{8'h78, 8'h61, 8'h62, 8'h79};
    send_pair(a, b, 1'b0);
    // Equal lengths, different contents.
    a = '{8'h61, 8'h62};
    b = '{8'h62, 8'h61};
    send_pair(a, b, 1'b0);
    // Extreme byte values, no match.
    a = '{8'h80, 8'h7F};
    b = '{8'h7F, 8'h80, 8'h55};
    send_pair(a, b, 1'b0);

    // Random pairs: mostly short, a handful near or past the buffer size.
    items_sent = 0;
    pairs      = 0;
    wide_done  = 0;
    held       = 1'b0;
    paused     = 1'b0;
    while (items_sent < RANDOM_ITEMS) begin
      // Park the receiver for a long stretch and keep feeding pairs so the
      // block backs up and drops s_tready.
      if (!held && items_sent >= 150) begin
        hold_request = LONG_HOLD;
        held         = 1'b1;
      end
      // Once, go quiet until every verdict is back.
      if (!paused && items_sent >= 350) begin
        s_tvalid = 1'b0;
        while (sb.pending() != 0) @(negedge clk);
        paused = 1'b1;
      end
      if (wide_done < 5 && pairs % 12 == 6) begin
        random_pair(1'b1);
        wide_done++;
      end else begin
        random_pair(1'b0);
      end
      pairs++;
    end

    s_tvalid = 1'b0;
    s_tlast  = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (sb.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
